FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by quaternion_report_to_euler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is off while reset is asserted.
`define QRE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define QRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/qre_pkg.sv
// ----------------------------------------------------------------------------
// qre_pkg
// Types, widths and the CORDIC angle table of the quaternion to Euler block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package qre_pkg;

	localparam int CW     = 36;  // CORDIC x/y width
	localparam int ZW     = 33;  // angle accumulator width
	localparam int AW     = 16;  // angle output width
	localparam int APB_AW = 3;

	localparam logic       REG_EXP_ID   = 1'b0;
	localparam logic [7:0] RESET_EXP_ID = 8'h05;

	localparam logic signed [ZW-1:0] QUARTER_Z = 33'sd589824000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} atan_in_t;

	typedef struct packed {
		atan_in_t roll;
		atan_in_t yaw;
		coord_t   s;
	} side_t;

	// atan(2^-n) in hundredths of a degree times 2^16
	function automatic logic signed [ZW-1:0] atan_entry(input int unsigned n);
		logic signed [ZW-1:0] r;
		case (n)
			0: r = 33'sd294912000;
			1: r = 33'sd174096719;
			2: r = 33'sd91987925;
			3: r = 33'sd46694507;
			4: r = 33'sd23437865;
			5: r = 33'sd11730358;
			6: r = 33'sd5866610;
			7: r = 33'sd2933484;
			8: r = 33'sd1466764;
			9: r = 33'sd733385;
			10: r = 33'sd366693;
			11: r = 33'sd183346;
			12: r = 33'sd91673;
			13: r = 33'sd45837;
			14: r = 33'sd22918;
			15: r = 33'sd11459;
			16: r = 33'sd5730;
			17: r = 33'sd2865;
			18: r = 33'sd1432;
			19: r = 33'sd716;
			20: r = 33'sd358;
			21: r = 33'sd179;
			22: r = 33'sd90;
			23: r = 33'sd45;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/qre_prod.sv
// ----------------------------------------------------------------------------
// qre_prod
// Quaternion products, atan2 arguments, pitch sine and 1 - s^2 (4 stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qre_prod #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic signed [15:0]  qi,
	input  logic signed [15:0]  qj,
	input  logic signed [15:0]  qk,
	input  logic signed [15:0]  qr,
	output logic                out_vld,
	output logic [4*QUAT_FRAC_BITS+1:0] v,
	output qre_pkg::side_t      side
);
	import qre_pkg::*;

	localparam int SW = 2*QUAT_FRAC_BITS + 1;
	localparam int VW = 4*QUAT_FRAC_BITS + 2;
	localparam coord_t ONE = coord_t'({{(CW-1){1'b0}}, 1'b1} << (2*QUAT_FRAC_BITS));
	localparam coord_t NEG_ONE = -ONE;
	localparam logic [VW-1:0] ONE4 = {{(VW-1){1'b0}}, 1'b1} << (4*QUAT_FRAC_BITS);

	logic vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [31:0] ri_s2, jk_s2, ii_s2, jj_s2, rk_s2, ij_s2, kk_s2, rj_s2, ki_s2;
	side_t side_s3, side_s4, side_s5;
	logic [VW-1:0] sq_s4, v_s5;

	coord_t roll_y, roll_x, yaw_y, yaw_x, s_raw, s_clamp;
	logic [SW-1:0] s_abs;

	always_comb begin
		roll_y = (coord_t'(ri_s2) + coord_t'(jk_s2)) <<< 1;
		roll_x = ONE - ((coord_t'(ii_s2) + coord_t'(jj_s2)) <<< 1);
		yaw_y  = (coord_t'(rk_s2) + coord_t'(ij_s2)) <<< 1;
		yaw_x  = ONE - ((coord_t'(jj_s2) + coord_t'(kk_s2)) <<< 1);
		s_raw  = (coord_t'(rj_s2) - coord_t'(ki_s2)) <<< 1;
		if (s_raw > ONE) begin
			s_clamp = ONE;
		end else if (s_raw < NEG_ONE) begin
			s_clamp = NEG_ONE;
		end else begin
			s_clamp = s_raw;
		end
		s_abs = side_s3.s[CW-1] ? SW'(-side_s3.s) : SW'(side_s3.s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s2 <= in_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ri_s2 <= 32'(qr) * 32'(qi);
			jk_s2 <= 32'(qj) * 32'(qk);
			ii_s2 <= 32'(qi) * 32'(qi);
			jj_s2 <= 32'(qj) * 32'(qj);
			rk_s2 <= 32'(qr) * 32'(qk);
			ij_s2 <= 32'(qi) * 32'(qj);
			kk_s2 <= 32'(qk) * 32'(qk);
			rj_s2 <= 32'(qr) * 32'(qj);
			ki_s2 <= 32'(qk) * 32'(qi);
			side_s3.roll.y <= roll_y;
			side_s3.roll.x <= roll_x;
			side_s3.yaw.y  <= yaw_y;
			side_s3.yaw.x  <= yaw_x;
			side_s3.s      <= s_clamp;
			side_s4 <= side_s3;
			sq_s4   <= VW'(s_abs) * VW'(s_abs);
			side_s5 <= side_s4;
			v_s5    <= ONE4 - sq_s4;
		end
	end

	assign out_vld = vld_s5;
	assign v       = v_s5;
	assign side    = side_s5;

endmodule
`default_nettype wire

FILE: sv/qre_isqrt.sv
// ----------------------------------------------------------------------------
// qre_isqrt
// Pipelined integer square root, one root digit per stage, sideband carried.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qre_isqrt #(
	parameter int QUAT_FRAC_BITS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [4*QUAT_FRAC_BITS+1:0] v,
	input  qre_pkg::side_t              in_side,
	output logic                        out_vld,
	output logic [2*QUAT_FRAC_BITS:0]   root,
	output qre_pkg::side_t              out_side
);
	import qre_pkg::*;

	localparam int SQ_DIG = 2*QUAT_FRAC_BITS + 1;
	localparam int VW     = 2*SQ_DIG;
	localparam int RW     = SQ_DIG + 3;

	logic              vld_s  [SQ_DIG];
	logic [RW-1:0]     rem_s  [SQ_DIG];
	logic [SQ_DIG-1:0] root_s [SQ_DIG];
	logic [VW-1:0]     vr_s   [SQ_DIG];
	side_t             side_s [SQ_DIG];

	for (genvar k = 0; k < SQ_DIG; k++) begin : g_stage
		logic              vld_in;
		logic [RW-1:0]     rem_in, rem_t, trial;
		logic [SQ_DIG-1:0] root_in;
		logic [VW-1:0]     vr_in;
		side_t             side_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign root_in = '0;
			assign vr_in   = v;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign vr_in   = vr_s[k-1];
			assign side_in = side_s[k-1];
		end

		always_comb begin
			rem_t = {rem_in[RW-3:0], vr_in[VW-1 -: 2]};
			trial = {1'b0, root_in, 2'b01};
			ge    = (rem_t >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_t - trial : rem_t;
				root_s[k] <= {root_in[SQ_DIG-2:0], ge};
				vr_s[k]   <= {vr_in[VW-3:0], 2'b00};
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[SQ_DIG-1];
	assign root     = root_s[SQ_DIG-1];
	assign out_side = side_s[SQ_DIG-1];

endmodule
`default_nettype wire

FILE: sv/qre_cordic.sv
// ----------------------------------------------------------------------------
// qre_cordic
// Pipelined vectoring CORDIC atan2, one rotation per stage, rounded and clamped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module qre_cordic #(
	parameter int STEPS = 16,
	parameter int LIMIT = 18000
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  qre_pkg::atan_in_t         in_arg,
	output logic                      out_vld,
	output logic signed [qre_pkg::AW-1:0] cdeg
);
	import qre_pkg::*;

	localparam int CDW = ZW - 16;
	localparam logic signed [CDW-1:0] LIM     = CDW'(LIMIT);
	localparam logic signed [CDW-1:0] NEG_LIM = -LIM;
	localparam logic signed [ZW-1:0]  HALF    = ZW'(32768);

	logic                 vld_s  [STEPS+1];
	logic                 zero_s [STEPS+1];
	coord_t               x_s    [STEPS+1];
	coord_t               y_s    [STEPS+1];
	logic signed [ZW-1:0] z_s    [STEPS+1];

	logic                  vld_out_q;
	logic signed [AW-1:0]  cdeg_q;

	// Pre-rotate the left half plane by a quarter turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_arg.x == '0) && (in_arg.y == '0);
			if (in_arg.x[CW-1] && !in_arg.y[CW-1]) begin
				x_s[0] <= in_arg.y;
				y_s[0] <= -in_arg.x;
				z_s[0] <= QUARTER_Z;
			end else if (in_arg.x[CW-1]) begin
				x_s[0] <= -in_arg.y;
				y_s[0] <= in_arg.x;
				z_s[0] <= -QUARTER_Z;
			end else begin
				x_s[0] <= in_arg.x;
				y_s[0] <= in_arg.y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic signed [ZW-1:0] ANG = atan_entry(k);
		coord_t dx, dy;

		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				if (!y_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + ANG;
				end else begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - ANG;
				end
			end
		end
	end

	logic signed [ZW-1:0]  z_round;
	logic signed [CDW-1:0] cd_raw, cd_clamp;

	always_comb begin
		z_round = z_s[STEPS] + HALF;
		cd_raw  = z_round[ZW-1:16];
		if (zero_s[STEPS]) begin
			cd_clamp = '0;
		end else if (cd_raw > LIM) begin
			cd_clamp = LIM;
		end else if (cd_raw < NEG_LIM) begin
			cd_clamp = NEG_LIM;
		end else begin
			cd_clamp = cd_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out_q <= 1'b0;
		end else if (en) begin
			vld_out_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cdeg_q <= cd_clamp[AW-1:0];
		end
	end

	assign out_vld = vld_out_q;
	assign cdeg    = cdeg_q;

endmodule
`default_nettype wire

FILE: sv/quaternion_report_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_report_to_euler
// Converts rotation vector reports (Q-format quaternions) to roll/pitch/yaw.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one report per transaction, s_tuser = report identifier,
//   s_tdata = quat_i, quat_j, quat_k, quat_real (16 bits each, low first).
//   A report whose identifier differs from the expected identifier (APB
//   register at byte address 0, reset 5) is consumed and gives no result.
//   Master stream: one transaction per matching report, m_tdata = roll,
//   pitch, yaw in hundredths of a degree, rounded half up.
//   Throughput: one report per cycle while the skid register is empty. The path
//   from acceptance to m_tvalid runs through the input register, four
//   product stages, one square root stage per root digit, and the CORDIC
//   pre-rotation, rotation and rounding stages, plus the output register.
//   Reset clears every valid bit and loads the identifier register with 5.
//   When the receiver stalls, the result waits in the output register and
//   one more result is parked in a skid register; only while the skid
//   register is full does the pipeline freeze and s_tready drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module quaternion_report_to_euler #(
	parameter int QUAT_FRAC_BITS = 14,
	parameter int CORDIC_STEPS   = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// quat_i [15:0], quat_j [31:16], quat_k [47:32], quat_real [63:48]
	input  logic [63:0]                 s_tdata,
	// report identifier [7:0]
	input  logic [7:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// roll_cdeg [15:0], pitch_cdeg [30:16], yaw_cdeg [46:31], zero [47]
	output logic [47:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [qre_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import qre_pkg::*;

	localparam int SQ_DIG = 2*QUAT_FRAC_BITS + 1;
	localparam int VW     = 2*SQ_DIG;

	// Configuration register; the register index is the word address bit.
	logic [7:0] exp_id_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EXP_ID) ? {24'b0, exp_id_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q <= RESET_EXP_ID;
		end else if (psel && penable && pwrite && paddr[2] == REG_EXP_ID) begin
			exp_id_q <= pwdata[7:0];
		end
	end

	// Global advance: the whole pipeline moves unless the skid slot is taken.
	logic en;
	logic skid_vld_q, out_vld_q;
	logic [47:0] skid_q, out_q;

	assign en       = !skid_vld_q;
	assign s_tready = en;

	// Input register: drop reports with another identifier here.
	logic vld_s1;
	logic signed [15:0] qi_s1, qj_s1, qk_s1, qr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid && (s_tuser == exp_id_q);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qi_s1 <= s_tdata[15:0];
			qj_s1 <= s_tdata[31:16];
			qk_s1 <= s_tdata[47:32];
			qr_s1 <= s_tdata[63:48];
		end
	end

	logic          prod_vld;
	logic [VW-1:0] prod_v;
	side_t         prod_side;

	qre_prod #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.qi      (qi_s1),
		.qj      (qj_s1),
		.qk      (qk_s1),
		.qr      (qr_s1),
		.out_vld (prod_vld),
		.v       (prod_v),
		.side    (prod_side)
	);

	logic              sq_vld;
	logic [SQ_DIG-1:0] sq_root;
	side_t             sq_side;

	qre_isqrt #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (prod_vld),
		.v        (prod_v),
		.in_side  (prod_side),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// Pitch is atan2(s, sqrt(1 - s^2)).
	atan_in_t pitch_arg;
	assign pitch_arg.y = sq_side.s;
	assign pitch_arg.x = coord_t'({{(CW-SQ_DIG){1'b0}}, sq_root});

	logic roll_vld, yaw_vld, pitch_vld;
	logic signed [AW-1:0] roll_cdeg, yaw_cdeg, pitch_cdeg;

	qre_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(18000)) u_roll (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_vld (sq_vld), .in_arg (sq_side.roll),
		.out_vld (roll_vld), .cdeg (roll_cdeg)
	);

	qre_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(18000)) u_yaw (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_vld (sq_vld), .in_arg (sq_side.yaw),
		.out_vld (yaw_vld), .cdeg (yaw_cdeg)
	);

	qre_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(9000)) u_pitch (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_vld (sq_vld), .in_arg (pitch_arg),
		.out_vld (pitch_vld), .cdeg (pitch_cdeg)
	);

	logic [47:0] result;
	logic        take;

	assign result = {1'b0, yaw_cdeg, pitch_cdeg[14:0], roll_cdeg};
	assign take   = out_vld_q && m_tready;

	// Output register plus skid slot: a finished result parks in the skid
	// slot when the output register is still held by the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (roll_vld) begin
			if (out_vld_q && !m_tready) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (roll_vld) begin
			if (out_vld_q && !m_tready) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	`QRE_ASSERT(a_lanes_aligned, clk, arst_n, (roll_vld == yaw_vld) && (roll_vld == pitch_vld), "CORDIC lanes out of step")
	`QRE_ASSERT(a_skid_behind_out, clk, arst_n, skid_vld_q |-> out_vld_q, "skid slot full with empty output")
	`QRE_ASSERT(a_pitch_range, clk, arst_n, m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd9000 && $signed(m_tdata[30:16]) >= -15'sd9000), "pitch out of range")

endmodule
`default_nettype wire
